// ===== src/hdsc_pkg.sv =====
// shared types, constants and helper functions of the drive setting converter
package hdsc_pkg;

	localparam int unsigned LATENCY = 35;
	localparam int unsigned SQRT_STAGES = 25;
	localparam logic [1:0] SAMPLE_TIME_RESET = 2'd3;

	localparam logic [29:0] RATED_RECIP = 30'd810102173;
	localparam logic [29:0] OD_RECIP = 30'd763989800;
	localparam logic [12:0] RECIP_625_Q22 = 13'd6711;
	localparam logic [30:0] RECIP_625_Q40 = 31'd1759218604;
	localparam logic [12:0] RECIP_10_Q16 = 13'd6554;
	localparam logic [4:0] DRIVE_MAX = 5'd31;
	localparam logic [7:0] CODE_MAX = 8'd255;

	// floor(5000/n) for n = 6 .. 36
	localparam logic [9:0] DT_THRESH [31] = '{
		10'd833, 10'd714, 10'd625, 10'd555, 10'd500, 10'd454, 10'd416, 10'd384,
		10'd357, 10'd333, 10'd312, 10'd294, 10'd277, 10'd263, 10'd250, 10'd238,
		10'd227, 10'd217, 10'd208, 10'd200, 10'd192, 10'd185, 10'd178, 10'd172,
		10'd166, 10'd161, 10'd156, 10'd151, 10'd147, 10'd142, 10'd138
	};

	typedef struct packed {
		logic [7:0] rv10;
		logic [7:0] od_code;
		logic [4:0] dt;
		logic       flag;
	} side_t;

	// round-half-up quotient by ten of an already offset value, clamped to 1..255
	function automatic logic [7:0] div10_clamp(input logic [15:0] u);
		logic [29:0] m;
		logic [13:0] q;
		logic [7:0] r;
		m = 30'(u) * 30'(RECIP_10_Q16);
		q = m[29:16];
		if (u >= 16'd2560) begin
			r = CODE_MAX;
		end else if (q == 14'd0) begin
			r = 8'd1;
		end else begin
			r = q[7:0];
		end
		return r;
	endfunction

	// floor(5000/f)-5 clamped to 0..31, as a count of thresholds
	function automatic logic [4:0] dt_from_freq(input logic [14:0] f);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 31; i++) begin
			if (f <= 15'(DT_THRESH[i])) begin
				n = n + 5'd1;
			end
		end
		return n;
	endfunction

endpackage

// ===== src/haptic_drive_setting_converter_top.sv =====
// top level of the haptic drive setting converter
// Usage:
//  - raise start with packed_word for one cycle to issue a beat; busy is
//    always low, so a new word may be issued in every cycle
//  - packed_word is byte-reversed packed BCD: rated volts, overdrive volts,
//    then a four digit frequency in Hz
//  - results appear on the result ports for exactly one cycle with done
//    high; throughput is one beat a cycle
//  - the path is the 25 stage square root pipeline, one root bit a
//    stage, plus six front stages and four scaling/output stages
//  - sample_time_code is written through cfg_valid/cfg_data; cfg_ready is
//    always high; write it only while no beat is in flight
//  - the receiver cannot stall: done is a strobe and must be taken when seen
//  - reset clears all valid bits and sets sample_time_code to 3; no
//    results are produced until a word is issued after reset
module haptic_drive_setting_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] packed_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	output logic        done,
	output logic [7:0]  rated_voltage_code,
	output logic [7:0]  overdrive_code,
	output logic [4:0]  drive_time_code,
	output logic        freq_out_of_range
);

	logic [1:0]      sample_time_q;
	logic            f_valid, r_valid;
	logic [24:0]     f_term, r_root;
	logic [27:0]     r_rem;
	hdsc_pkg::side_t f_side, r_side;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_time_q <= hdsc_pkg::SAMPLE_TIME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sample_time_q <= cfg_data;
		end
	end

	hdsc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (start && !busy),
		.packed_word      (packed_word),
		.sample_time_code (sample_time_q),
		.out_valid        (f_valid),
		.term             (f_term),
		.side             (f_side)
	);

	hdsc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.term      (f_term),
		.side_in   (f_side),
		.out_valid (r_valid),
		.root      (r_root),
		.rem       (r_rem),
		.side_out  (r_side)
	);

	hdsc_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (r_valid),
		.root               (r_root),
		.rem                (r_rem),
		.side_in            (r_side),
		.done               (done),
		.rated_voltage_code (rated_voltage_code),
		.overdrive_code     (overdrive_code),
		.drive_time_code    (drive_time_code),
		.freq_out_of_range  (freq_out_of_range)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##35 done)
		else $error("issued beat did not complete on time");
`endif

endmodule

// ===== src/hdsc_front.sv =====
// decode, correction term and fixed point term up to the square root input
module hdsc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [31:0]         packed_word,
	input  logic [1:0]          sample_time_code,
	output logic                out_valid,
	output logic [24:0]         term,
	output hdsc_pkg::side_t     side
);

	logic [31:0] c;
	logic [7:0]  rv10_d, od10_d;
	logic [14:0] freq_d;

	logic        v_s1;
	logic [7:0]  rv10_s1, od10_s1;
	logic [14:0] freq_s1;

	logic [3:0]  coef;
	logic [18:0] kf;
	logic        v_s2, flag_s2;
	logic [13:0] num_s2;
	logic [37:0] odp_s2;
	logic [4:0]  dt_s2;
	logic [7:0]  rv10_s2;

	logic [26:0] a_full;
	logic        v_s3;
	logic [4:0]  a_s3;
	logic [13:0] num_s3;
	hdsc_pkg::side_t side_s3;

	logic [13:0] a625;
	logic [9:0]  b;
	logic        v_s4;
	logic [4:0]  a_s4;
	logic [29:0] y_s4;
	hdsc_pkg::side_t side_s4;

	logic [60:0] prod;
	logic        v_s5;
	logic [4:0]  a_s5;
	logic [29:0] y_s5;
	logic [19:0] q0_s5;
	hdsc_pkg::side_t side_s5;

	logic [29:0] q625, r;
	logic [19:0] q;
	logic        v_s6;
	logic [24:0] t_s6;
	hdsc_pkg::side_t side_s6;

	assign c = {packed_word[7:0], packed_word[15:8], packed_word[23:16], packed_word[31:24]};
	assign rv10_d = {4'd0, c[31:28]} * 8'd10 + {4'd0, c[27:24]};
	assign od10_d = {4'd0, c[23:20]} * 8'd10 + {4'd0, c[19:16]};
	assign freq_d = 15'(c[15:12]) * 15'd1000 + 15'(c[11:8]) * 15'd100
		+ 15'(c[7:4]) * 15'd10 + 15'(c[3:0]);

	assign coef = 4'd9 + {1'b0, sample_time_code, 1'b0};
	assign kf = 19'(coef) * 19'(freq_s1);

	assign a_full = 27'(num_s2) * 27'(hdsc_pkg::RECIP_625_Q22);
	assign a625 = 14'(a_s3) * 14'd625;
	assign b = 10'(num_s3 - a625);
	assign prod = 61'(y_s4) * 61'(hdsc_pkg::RECIP_625_Q40);
	assign q625 = 30'(q0_s5) * 30'd625;
	assign r = y_s5 - q625;
	assign q = (r >= 30'd625) ? q0_s5 + 20'd1 : q0_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		rv10_s1 <= rv10_d;
		od10_s1 <= od10_d;
		freq_s1 <= freq_d;

		flag_s2 <= (kf > 19'd10000);
		num_s2 <= (kf > 19'd10000) ? 14'd0 : 14'(19'd10000 - kf);
		odp_s2 <= 38'(od10_s1) * 38'(hdsc_pkg::OD_RECIP);
		dt_s2 <= hdsc_pkg::dt_from_freq(freq_s1);
		rv10_s2 <= rv10_s1;

		a_s3 <= a_full[26:22];
		num_s3 <= num_s2;
		side_s3.rv10 <= rv10_s2;
		side_s3.od_code <= hdsc_pkg::div10_clamp(16'(odp_s2[37:24]) + 16'd5);
		side_s3.dt <= dt_s2;
		side_s3.flag <= flag_s2;

		// (num*2^24+5000)/10000 as (num%625*2^20+312)/625 plus a whole part
		a_s4 <= a_s3;
		y_s4 <= {b, 20'd312};
		side_s4 <= side_s3;

		a_s5 <= a_s4;
		y_s5 <= y_s4;
		q0_s5 <= prod[59:40];
		side_s5 <= side_s4;

		t_s6 <= {a_s5, q};
		side_s6 <= side_s5;
	end

	assign out_valid = v_s6;
	assign term = t_s6;
	assign side = side_s6;

`ifndef SYNTHESIS
	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> t_s6 <= 25'h1000000)
		else $error("term above one");
`endif

endmodule

// ===== src/hdsc_sqrt.sv =====
// pipelined digit by digit square root of term * 2^24, one result bit a stage
module hdsc_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [24:0]     term,
	input  hdsc_pkg::side_t side_in,
	output logic            out_valid,
	output logic [24:0]     root,
	output logic [27:0]     rem,
	output hdsc_pkg::side_t side_out
);

	localparam int unsigned N = hdsc_pkg::SQRT_STAGES;

	logic            v_s    [N];
	logic [27:0]     rem_s  [N];
	logic [24:0]     root_s [N];
	logic [24:0]     t_s    [N];
	hdsc_pkg::side_t side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic            v_p;
		logic [27:0]     rem_p;
		logic [24:0]     root_p, t_p;
		hdsc_pkg::side_t side_p;
		logic [49:0]     xw;
		logic [27:0]     rem_n, trial;

		if (k == 0) begin : g_first
			assign v_p = in_valid;
			assign rem_p = '0;
			assign root_p = '0;
			assign t_p = term;
			assign side_p = side_in;
		end else begin : g_next
			assign v_p = v_s[k-1];
			assign rem_p = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign t_p = t_s[k-1];
			assign side_p = side_s[k-1];
		end

		assign xw = {1'b0, t_p, 24'd0};
		assign rem_n = {rem_p[25:0], xw[2*(N-1-k)+1 -: 2]};
		assign trial = {1'b0, root_p, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (rem_n >= trial) begin
				rem_s[k] <= rem_n - trial;
				root_s[k] <= {root_p[23:0], 1'b1};
			end else begin
				rem_s[k] <= rem_n;
				root_s[k] <= {root_p[23:0], 1'b0};
			end
			t_s[k] <= t_p;
			side_s[k] <= side_p;
		end
	end

	assign out_valid = v_s[N-1];
	assign root = root_s[N-1];
	assign rem = rem_s[N-1];
	assign side_out = side_s[N-1];

`ifndef SYNTHESIS
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[N-1] |-> root_s[N-1] <= 25'h1000000 && rem_s[N-1] <= {2'b0, root_s[N-1], 1'b0})
		else $error("root or remainder out of range");
`endif

endmodule

// ===== src/hdsc_back.sv =====
// root rounding, rated voltage scaling and output registers
module hdsc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [24:0]     root,
	input  logic [27:0]     rem,
	input  hdsc_pkg::side_t side_in,
	output logic            done,
	output logic [7:0]      rated_voltage_code,
	output logic [7:0]      overdrive_code,
	output logic [4:0]      drive_time_code,
	output logic            freq_out_of_range
);

	logic            v_s1, v_s2, v_s3, v_s4;
	logic [24:0]     s_s1;
	logic [32:0]     m1_s2;
	logic [46:0]     pl_s3;
	logic [45:0]     ph_s3;
	logic [62:0]     p;
	logic [15:0]     u;
	hdsc_pkg::side_t side_s1, side_s2, side_s3;
	logic [7:0]      rated_s4, od_s4;
	logic [4:0]      dt_s4;
	logic            flag_s4;

	assign p = (63'(ph_s3) << 17) + 63'(pl_s3);
	assign u = 16'(p[62:48]) + 16'd5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		// round to nearest: remainder above root means past the half point
		s_s1 <= (28'(root) < rem) ? root + 25'd1 : root;
		side_s1 <= side_in;

		m1_s2 <= 33'(side_s1.rv10) * 33'(s_s1);
		side_s2 <= side_s1;

		pl_s3 <= 47'(m1_s2[16:0]) * 47'(hdsc_pkg::RATED_RECIP);
		ph_s3 <= 46'(m1_s2[32:17]) * 46'(hdsc_pkg::RATED_RECIP);
		side_s3 <= side_s2;

		rated_s4 <= side_s3.flag ? 8'd1 : hdsc_pkg::div10_clamp(u);
		od_s4 <= side_s3.od_code;
		dt_s4 <= side_s3.dt;
		flag_s4 <= side_s3.flag;
	end

	assign done = v_s4;
	assign rated_voltage_code = rated_s4;
	assign overdrive_code = od_s4;
	assign drive_time_code = dt_s4;
	assign freq_out_of_range = flag_s4;

`ifndef SYNTHESIS
	a_flag_rated: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && flag_s4 |-> rated_s4 == 8'd1)
		else $error("out of range beat without minimum rated code");
	a_codes_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> rated_s4 != 8'd0 && od_s4 != 8'd0)
		else $error("code below clamp");
`endif

endmodule
